/* hdl/can_signal_extractor_defines.svh */
// ----------------------------------------------------------------------------
// CAN signal extractor assertion macros
// Shared checking macros for the signal extractor.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACTOR_DEFINES_SVH
`define CAN_SIGNAL_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cse_pkg.sv */
// ----------------------------------------------------------------------------
// CAN signal extractor package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int FRAME_IDS_DEF      = 2048;
    localparam int SIGNAL_ENTRIES_DEF = 256;
    localparam int MAX_SIG_DEF        = 16;

    localparam logic [1:0] CMD_DECODE   = 2'd0;
    localparam logic [1:0] CMD_FRAME_WR = 2'd1;
    localparam logic [1:0] CMD_SIG_WR   = 2'd2;
    localparam logic [1:0] CMD_RSVD     = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [10:0]        can_id;
        logic [63:0]        payload;
        logic [7:0]         signal_index;
        logic [4:0]         num_signals;
        logic [5:0]         start_bit;
        logic [5:0]         bit_length;
        logic               big_endian;
        logic               twos_comp;
        logic signed [31:0] scale;
        logic signed [47:0] offset_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         signal_id;
        logic signed [63:0] value;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] first;
        logic [4:0] count;
    } t_frame_entry;

    typedef struct packed {
        logic [5:0]         start_bit;
        logic [5:0]         bit_length;
        logic               big_endian;
        logic               twos_comp;
        logic signed [31:0] scale;
        logic signed [47:0] offset_value;
    } t_sig_entry;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
    } t_sig_req;

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    function automatic logic [63:0] rev_bytes_bits(input logic [63:0] v);
        logic [63:0] r;
        for (int n = 0; n < 8; n++) begin
            for (int j = 0; j < 8; j++) begin
                r[8 * n + j] = v[8 * n + 7 - j];
            end
        end
        return r;
    endfunction

endpackage

/* hdl/cse_frame_mem.sv */
// ----------------------------------------------------------------------------
// CAN signal extractor frame table
// Frame table memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cse_frame_mem #(
    parameter int FRAME_IDS = cse_pkg::FRAME_IDS_DEF,
    parameter int AW        = 11
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  cse_pkg::t_frame_entry i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output cse_pkg::t_frame_entry o_rd_data
);
    import cse_pkg::*;

    t_frame_entry r_mem [FRAME_IDS];
    t_frame_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

/* hdl/cse_sig_mem.sv */
// ----------------------------------------------------------------------------
// CAN signal extractor signal table
// Signal definition memory with a registered read and out-of-range handling.
// ----------------------------------------------------------------------------
module cse_sig_mem #(
    parameter int SIGNAL_ENTRIES = cse_pkg::SIGNAL_ENTRIES_DEF,
    parameter int AW             = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [7:0]          i_wr_idx,
    input  cse_pkg::t_sig_entry i_wr_data,
    input  cse_pkg::t_sig_req   i_rd_req,
    output logic                o_rd_valid,
    output cse_pkg::t_sig_entry o_rd_data
);
    import cse_pkg::*;

    t_sig_entry r_mem [SIGNAL_ENTRIES];
    t_sig_entry r_rd;
    logic       r_valid;
    logic       r_oor;
    logic       rd_in_range;
    logic       wr_in_range;

    assign rd_in_range = 32'(i_rd_req.idx) < SIGNAL_ENTRIES;
    assign wr_in_range = 32'(i_wr_idx) < SIGNAL_ENTRIES;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[AW'(i_wr_idx)] <= i_wr_data;
        end
        r_rd  <= r_mem[AW'(i_rd_req.idx)];
        r_oor <= !rd_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_rd_req.en;
        end
    end

    assign o_rd_valid = r_valid;
    assign o_rd_data  = r_oor ? '0 : r_rd;
endmodule

/* hdl/cse_datapath.sv */
// ----------------------------------------------------------------------------
// CAN signal extractor datapath
// Three-stage pipeline: bit extraction, scaling multiply, offset add with saturation.
// ----------------------------------------------------------------------------
module cse_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cse_pkg::t_sig_entry i_sig,
    input  logic [63:0]         i_payload,
    output logic                o_valid,
    output logic signed [63:0]  o_value
);
    import cse_pkg::*;

    logic [5:0]         len;
    logic [5:0]         pos;
    logic [6:0]         avail;
    logic [5:0]         k;
    logic [31:0]        mask;
    logic [63:0]        shifted;
    logic [31:0]        raw;
    logic               neg;
    logic signed [32:0] ext;

    logic               r_v1;
    logic signed [32:0] r_raw;
    logic signed [31:0] r_scale;
    logic signed [47:0] r_off1;
    logic               r_v2;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_off2;
    logic               r_v3;
    logic signed [63:0] r_value;

    logic signed [64:0] prod_full;
    logic signed [64:0] sum;

    always_comb begin
        len = (i_sig.bit_length > 6'd32) ? 6'd32 : i_sig.bit_length;
        if (i_sig.big_endian) begin
            pos     = {i_sig.start_bit[5:3], ~i_sig.start_bit[2:0]};
            shifted = rev_bytes_bits(i_payload) >> pos;
        end else begin
            pos     = i_sig.start_bit;
            shifted = i_payload >> pos;
        end
        avail = 7'd64 - {1'b0, pos};
        k     = ({1'b0, len} > avail) ? avail[5:0] : len;
        mask  = 32'((33'd1 << k) - 33'd1);
        if (k == 6'd0) begin
            raw = '0;
        end else if (i_sig.big_endian) begin
            raw = rev32(shifted[31:0] & mask) >> (6'd32 - k);
        end else begin
            raw = shifted[31:0] & mask;
        end
        neg = i_sig.twos_comp && (len != 6'd0) && (len < 6'd32)
              && raw[5'(len - 6'd1)];
        if (neg) begin
            ext = $signed({1'b0, raw} - (33'd1 << len));
        end else begin
            ext = $signed({1'b0, raw});
        end
    end

    assign prod_full = r_raw * r_scale;
    assign sum = {r_prod[63], r_prod} + {{17{r_off2[47]}}, r_off2};

    always_ff @(posedge i_clk) begin
        r_raw   <= ext;
        r_scale <= i_sig.scale;
        r_off1  <= i_sig.offset_value;
        r_prod  <= prod_full[63:0];
        r_off2  <= r_off1;
        if (sum[64] != sum[63]) begin
            r_value <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r_value <= sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r_value;
endmodule

/* hdl/can_signal_extractor.sv */
// ----------------------------------------------------------------------------
// CAN signal extractor
// Decodes DBC-style signals from standard CAN data frames using host-loaded tables.
// ----------------------------------------------------------------------------
// After reset the block clears its frame table, one entry per cycle, and
// accepts no item until every entry is cleared. Table writes leave the block
// idle. A decoded frame first passes the frame table lookup, then each
// signal passes the signal table read and the three-stage extract, multiply
// and saturate pipeline and waits for the output handshake before the next
// one starts. One item is handled at a time.
module can_signal_extractor #(
    parameter int FRAME_IDS      = cse_pkg::FRAME_IDS_DEF,
    parameter int SIGNAL_ENTRIES = cse_pkg::SIGNAL_ENTRIES_DEF,
    parameter int MAX_SIGNALS    = cse_pkg::MAX_SIG_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cse_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cse_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import cse_pkg::*;
    `include "can_signal_extractor_defines.svh"

    localparam int FRAME_AW = (FRAME_IDS > 1) ? $clog2(FRAME_IDS) : 1;
    localparam int SIG_AW   = (SIGNAL_ENTRIES > 1) ? $clog2(SIGNAL_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_SIGNALS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FRAME = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [FRAME_AW-1:0] r_clr, n_clr;
    logic                r_enable;
    logic [63:0]         r_payload;
    logic [7:0]          r_idx, n_idx;
    logic [CNT_W-1:0]    r_left, n_left;
    logic signed [63:0]  r_value;

    logic                accept;
    logic                id_ok;
    logic                fr_wr_en;
    logic [FRAME_AW-1:0] fr_wr_addr;
    t_frame_entry        fr_wr_data;
    t_frame_entry        fr_rd_data;
    logic [6:0]          cnt_clamp;
    t_sig_req            sig_req;
    t_sig_entry          sig_wr_data;
    logic                sig_rd_valid;
    t_sig_entry          sig_rd_data;
    logic                dp_valid;
    logic signed [63:0]  dp_value;
    logic                out_done;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign id_ok       = 32'(i_in_item.can_id) < FRAME_IDS;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            fr_wr_en   = 1'b1;
            fr_wr_addr = r_clr;
            fr_wr_data = '0;
        end else begin
            fr_wr_en   = accept && (i_in_item.command == CMD_FRAME_WR) && id_ok;
            fr_wr_addr = FRAME_AW'(i_in_item.can_id);
            fr_wr_data = '{first: i_in_item.signal_index, count: i_in_item.num_signals};
        end
    end

    assign sig_wr_data = '{start_bit:    i_in_item.start_bit,
                           bit_length:   i_in_item.bit_length,
                           big_endian:   i_in_item.big_endian,
                           twos_comp:    i_in_item.twos_comp,
                           scale:        i_in_item.scale,
                           offset_value: i_in_item.offset_value};

    assign sig_req.en  = (r_state == ST_READ);
    assign sig_req.idx = r_idx;

    assign cnt_clamp = ({2'b0, fr_rd_data.count} > 7'(MAX_SIGNALS))
                       ? 7'(MAX_SIGNALS) : {2'b0, fr_rd_data.count};

    cse_frame_mem #(
        .FRAME_IDS (FRAME_IDS),
        .AW        (FRAME_AW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (fr_wr_en),
        .i_wr_addr (fr_wr_addr),
        .i_wr_data (fr_wr_data),
        .i_rd_addr (FRAME_AW'(i_in_item.can_id)),
        .o_rd_data (fr_rd_data)
    );

    cse_sig_mem #(
        .SIGNAL_ENTRIES (SIGNAL_ENTRIES),
        .AW             (SIG_AW)
    ) u_sig_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && (i_in_item.command == CMD_SIG_WR)),
        .i_wr_idx   (i_in_item.signal_index),
        .i_wr_data  (sig_wr_data),
        .i_rd_req   (sig_req),
        .o_rd_valid (sig_rd_valid),
        .o_rd_data  (sig_rd_data)
    );

    cse_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sig_rd_valid),
        .i_sig     (sig_rd_data),
        .i_payload (r_payload),
        .o_valid   (dp_valid),
        .o_value   (dp_value)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_idx   = r_idx;
        n_left  = r_left;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == FRAME_AW'(FRAME_IDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_in_item.command == CMD_DECODE) && r_enable && id_ok) begin
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: begin
                n_idx  = fr_rd_data.first;
                n_left = CNT_W'(cnt_clamp);
                n_state = (cnt_clamp == 7'd0) ? ST_IDLE : ST_READ;
            end
            ST_READ: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (dp_valid) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 8'd1;
                        n_left  = r_left - CNT_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_enable <= 1'b0;
            r_idx    <= '0;
            r_left   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_left  <= n_left;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= i_in_item.payload;
        end
        if (dp_valid) begin
            r_value <= dp_value;
        end
    end

    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_item  = '{signal_id: r_idx, value: r_value, last: (r_left == CNT_W'(1))};
    assign out_done    = o_out_valid && i_out_ready && o_out_item.last;

    `CSE_ASSERT_IMP(a_no_overlap, o_out_valid, !o_in_ready, "input taken while a result waits")
    `CSE_ASSERT_NXT(a_last_frees, out_done, o_in_ready, "block not idle after last result")
    `CSE_ASSERT_IMP(a_dp_in_wait, dp_valid, r_state == ST_WAIT, "datapath result outside wait state")
endmodule
